@@ rtl/stdf_pkg.sv @@
// Package: widths, register indexes, sine table and shared types of the tape delay.
package stdf_pkg;

	localparam int AddrW = 17;
	localparam int DataW = 24;
	localparam int SineW = 10;
	localparam int SineQuarter = 2**(SineW-2);

	localparam logic [2:0] RegTargetDelay = 3'd0;
	localparam logic [2:0] RegFeedbackGain = 3'd1;
	localparam logic [2:0] RegFlutterDepth = 3'd2;
	localparam logic [2:0] RegLfoOneStep = 3'd3;
	localparam logic [2:0] RegLfoTwoStep = 3'd4;
	localparam logic [2:0] RegSmoothing = 3'd5;
	localparam logic [2:0] RegDcBlock = 3'd6;

	// request from the sequencer to one channel lane
	typedef struct packed {
		logic                start;
		logic [AddrW-1:0]    index;
		logic [15:0]         frac;
		logic [AddrW-1:0]    wr_addr;
		logic signed [15:0]  sample;
		logic [14:0]         fb_gain;
		logic [15:0]         dc_coef;
	} lane_req_t;

	// reply from one channel lane
	typedef struct packed {
		logic                done;
		logic signed [15:0]  sample;
	} lane_rsp_t;

	typedef logic signed [15:0] sine_quarter_t [SineQuarter+1];

	// One quarter-wave point, Q1.15: Taylor series in Q30, rounded
	function automatic logic signed [15:0] sine_point(input int j);
		logic [63:0] part, x, x2, term;
		longint      sum, q15;
		part = 64'(j) << 22;
		x = (part * 64'd1686629713) >> 30;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int n = 1; n <= 6; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n[0]) sum -= longint'(term);
			else sum += longint'(term);
		end
		if (sum < 0) sum = 0;
		q15 = (sum + 16384) >>> 15;
		if (q15 > 32767) q15 = 32767;
		return 16'(q15);
	endfunction

	function automatic sine_quarter_t build_quarter();
		sine_quarter_t t;
		for (int j = 0; j <= SineQuarter; j++) t[j] = sine_point(j);
		return t;
	endfunction

	// Quarter-wave sine, 0 to a quarter turn inclusive
	localparam sine_quarter_t SineRom = build_quarter();

	// Full-turn lookup: mirror on odd quarters, negate on the second half
	function automatic logic signed [15:0] sine_lookup(input logic [SineW-1:0] idx);
		logic [SineW-2:0]   j;
		logic signed [15:0] v;
		j = idx[SineW-2] ? (SineW-1)'(SineQuarter) - (SineW-1)'(idx[SineW-3:0])
			: (SineW-1)'(idx[SineW-3:0]);
		v = SineRom[j];
		return idx[SineW-1] ? -v : v;
	endfunction

	function automatic logic signed [DataW-1:0] sat24(input logic signed [47:0] v);
		if (v > 48'sd8388607) return 24'sh7FFFFF;
		if (v < -48'sd8388608) return 24'sh800000;
		return v[DataW-1:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
		if (v > 48'sd32767) return 16'sh7FFF;
		if (v < -48'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

endpackage

@@ rtl/stdf_if.sv @@
// Interfaces: sample channel and configuration write channel.
interface stdf_stream_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left;
	logic signed [15:0] right;
	modport source (output valid, output left, output right, input ready);
	modport sink (input valid, input left, input right, output ready);
endinterface

interface stdf_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/stereo_tape_delay_with_flutter.sv @@
// Top level: stereo tape delay with flutter, two channel lanes and a controller.
// Usage:
//  in_ch carries one stereo Q1.15 pair per word (valid/ready); out_ch returns
//  one dry-plus-wet pair per accepted word. cfg writes registers 0..6 by index
//  and is always ready; write it only while the block is idle.
//  Only one word is in flight, and a new word is taken only after the last
//  result has drained. The controller steps through smoothing, LFO mix,
//  offset and position; each lane then steps through four reads of the ring
//  store, a settle step, coefficients, three Horner steps, wet, feedback
//  scale, two cube steps, the divide by three, DC blocker and the write; then
//  the controller registers the result and returns to idle once it drains.
//  After reset both 131072-entry stores are swept to zero, one entry a
//  cycle; in_ch.ready stays low during the sweep.
//  Registers return to their reset values at once.
//  If out_ch stalls, the result holds and no new word is taken until it
//  drains.
module stereo_tape_delay_with_flutter (
	input logic           clk,
	input logic           arst_n,
	stdf_stream_if.sink   in_ch,
	stdf_stream_if.source out_ch,
	stdf_cfg_if.sink      cfg
);
	import stdf_pkg::*;

	lane_req_t req_l, req_r;
	lane_rsp_t rsp_l, rsp_r;
	logic busy_l, busy_r;

	stdf_ctrl u_ctrl (
		.clk, .arst_n, .in_ch, .out_ch, .cfg,
		.req_l, .req_r, .rsp_l, .rsp_r, .clear_busy(busy_l | busy_r)
	);
	stdf_lane u_left (.clk, .arst_n, .req(req_l), .rsp(rsp_l), .clear_busy(busy_l));
	stdf_lane u_right (.clk, .arst_n, .req(req_r), .rsp(rsp_r), .clear_busy(busy_r));
endmodule

@@ rtl/stdf_lane.sv @@
// One channel lane: ring store, Hermite read, feedback path and DC blocker.
module stdf_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  stdf_pkg::lane_req_t req,
	output stdf_pkg::lane_rsp_t rsp,
	output logic               clear_busy
);
	import stdf_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RD, S_C1, S_H1, S_H2, S_H3, S_WET, S_FB, S_CUBE1, S_CUBE2,
		S_DIV, S_DC, S_WR
	} state_t;

	state_t               state_q;
	logic [AddrW:0]       clr_q;
	logic [1:0]           tap_q;
	logic                 rd_en;
	logic [AddrW-1:0]     rd_addr;
	logic signed [DataW-1:0] rd_data_q;
	logic signed [DataW-1:0] y_q [4];
	logic                 got_q;
	logic [1:0]           got_idx_q;
	logic signed [47:0]   t_q, c2_q, c3_q, x_q, sq_q, cube_q;
	logic signed [DataW-1:0] wet_q, clip_q, prev_in_q, prev_out_q;
	logic signed [DataW-1:0] mem [2**AddrW];
	logic                 we;
	logic [AddrW-1:0]     wa;
	logic signed [DataW-1:0] wd;
	logic signed [47:0]   f_s, dcy, third;
	logic [31:0]          cube_mag;
	logic [63:0]          third_prod;

	assign f_s = 48'(signed'({1'b0, req.frac}));

	// clearing sweep, then per-item writes
	always_comb begin
		we = 1'b0;
		wa = req.wr_addr;
		wd = '0;
		if (state_q == S_CLEAR) begin
			we = 1'b1;
			wa = clr_q[AddrW-1:0];
		end else if (state_q == S_WR) begin
			we = 1'b1;
			wd = sat24(48'(signed'({req.sample, 5'b0})) + 48'(prev_out_q));
		end
	end

	assign rd_en = (state_q == S_RD);
	assign rd_addr = req.index + AddrW'(tap_q) - AddrW'(1);

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	// divide the cube by three, truncating toward zero, by reciprocal multiply
	assign cube_mag = cube_q[47] ? 32'(-cube_q) : 32'(cube_q);
	assign third_prod = 64'(cube_mag) * 64'(32'hAAAA_AAAB);
	assign third = cube_q[47] ? -48'(third_prod[63:33]) : 48'(third_prod[63:33]);

	assign dcy = 48'(clip_q) - 48'(prev_in_q)
		+ ((48'(signed'({1'b0, req.dc_coef})) * 48'(prev_out_q)) >>> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			tap_q      <= '0;
			got_q      <= 1'b0;
			got_idx_q  <= '0;
			prev_in_q  <= '0;
			prev_out_q <= '0;
			rsp        <= '0;
		end else begin
			got_q    <= rd_en;
			got_idx_q <= tap_q;
			if (got_q) y_q[got_idx_q] <= rd_data_q;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AddrW+1)'(2**AddrW - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					rsp.done <= 1'b0;
					if (req.start) begin
						tap_q   <= '0;
						state_q <= S_RD;
					end
				end
				// read the four taps, one a cycle
				S_RD: begin
					tap_q <= tap_q + 1'b1;
					if (tap_q == 2'd3) state_q <= S_C1;
				end
				S_C1: if (!got_q) begin
					c2_q <= 48'(y_q[0]) * 2 - 48'(y_q[1]) * 5 + 48'(y_q[2]) * 4 - 48'(y_q[3]);
					c3_q <= 48'(y_q[3]) - 48'(y_q[0]) + 3 * (48'(y_q[1]) - 48'(y_q[2]));
					state_q <= S_H1;
				end
				// Horner steps
				S_H1: begin
					t_q <= ((c3_q * f_s) >>> 16) + c2_q;
					state_q <= S_H2;
				end
				S_H2: begin
					t_q <= ((t_q * f_s) >>> 16) + 48'(y_q[2]) - 48'(y_q[0]);
					state_q <= S_H3;
				end
				S_H3: begin
					t_q <= ((t_q * f_s) >>> 16) + 2 * 48'(y_q[1]);
					state_q <= S_WET;
				end
				S_WET: begin
					wet_q   <= sat24(t_q >>> 1);
					state_q <= S_FB;
				end
				S_FB: begin
					x_q <= (48'(wet_q) * 48'(signed'({1'b0, req.fb_gain}))) >>> 15;
					rsp.sample <= sat16(48'(req.sample) + (48'(wet_q) >>> 5));
					state_q <= S_CUBE1;
				end
				S_CUBE1: begin
					sq_q    <= (x_q * x_q) >>> 20;
					state_q <= S_CUBE2;
				end
				S_CUBE2: begin
					cube_q  <= 48'((64'(sq_q) * 64'(x_q)) >>> 20);
					state_q <= S_DIV;
				end
				S_DIV: begin
					clip_q  <= sat24(x_q - third);
					state_q <= S_DC;
				end
				S_DC: begin
					prev_in_q  <= clip_q;
					prev_out_q <= sat24(dcy);
					state_q    <= S_WR;
				end
				S_WR: begin
					rsp.done <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign clear_busy = (state_q == S_CLEAR);

	ap_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy |-> !rsp.done) else $error("lane answered during clear");
	ap_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done) else $error("done held");
	ap_wr_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR) |=> (state_q == S_IDLE)) else $error("write not single");
endmodule

@@ rtl/stdf_ctrl.sv @@
// Control: registers, delay smoothing, LFOs, read position and lane sequencing.
module stdf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	stdf_stream_if.sink         in_ch,
	stdf_stream_if.source       out_ch,
	stdf_cfg_if.sink            cfg,
	output stdf_pkg::lane_req_t req_l,
	output stdf_pkg::lane_req_t req_r,
	input  stdf_pkg::lane_rsp_t rsp_l,
	input  stdf_pkg::lane_rsp_t rsp_r,
	input  logic                clear_busy
);
	import stdf_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_SMOOTH, S_MIX, S_OFF1, S_OFF2, S_POS, S_RUN, S_OUT}
		state_t;

	state_t state_q;
	logic [24:0] target_q;
	logic [14:0] fb_q;
	logic [15:0] depth_q, smooth_q, dc_q;
	logic [23:0] step1_q, step2_q, ph1_q, ph2_q;
	logic signed [35:0] sd_q;
	logic signed [47:0] mix_q, k_q, off_q, prod_q;
	logic [AddrW-1:0] wp_q;
	logic [AddrW+15:0] pos_q;
	logic signed [15:0] l_q, r_q;
	logic signed [35:0] diff;
	logic signed [15:0] s1, s2;

	assign cfg.ready = 1'b1;
	assign in_ch.ready = (state_q == S_IDLE) && !clear_busy;
	assign diff = 36'(signed'({3'b0, target_q, 8'b0})) - sd_q;
	assign s1 = sine_lookup(ph1_q[23:24-SineW]);
	assign s2 = sine_lookup(ph2_q[23:24-SineW]);

	always_comb begin
		req_l = '0;
		req_l.start   = (state_q == S_POS);
		req_l.index   = pos_q[AddrW+15:16];
		req_l.frac    = pos_q[15:0];
		req_l.wr_addr = wp_q;
		req_l.sample  = l_q;
		req_l.fb_gain = fb_q;
		req_l.dc_coef = dc_q;
		req_r = req_l;
		req_r.sample = r_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			target_q <= '0; fb_q <= '0; depth_q <= '0;
			step1_q <= '0; step2_q <= '0; smooth_q <= 16'd66; dc_q <= 16'd65208;
			sd_q <= '0; ph1_q <= '0; ph2_q <= '0; wp_q <= '0; pos_q <= '0;
			out_ch.valid <= 1'b0;
		end else begin
			// register writes
			if (cfg.valid) begin
				unique case (cfg.index)
					RegTargetDelay:  target_q <= cfg.data[24:0];
					RegFeedbackGain: fb_q     <= cfg.data[14:0];
					RegFlutterDepth: depth_q  <= cfg.data[15:0];
					RegLfoOneStep:   step1_q  <= cfg.data[23:0];
					RegLfoTwoStep:   step2_q  <= cfg.data[23:0];
					RegSmoothing:    smooth_q <= cfg.data[15:0];
					RegDcBlock:      dc_q     <= cfg.data[15:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: if (in_ch.valid && in_ch.ready) begin
					l_q <= in_ch.left;
					r_q <= in_ch.right;
					state_q <= S_SMOOTH;
				end
				S_SMOOTH: begin
					sd_q <= sd_q + 36'((52'(signed'({1'b0, smooth_q})) * 52'(diff)) >>> 16);
					mix_q <= (48'(s1) * 48'sd19661 + 48'(s2) * 48'sd13107) >>> 15;
					k_q <= 48'((32'(depth_q) * 32'd2621) >> 16);
					ph1_q <= ph1_q + step1_q;
					ph2_q <= ph2_q + step2_q;
					state_q <= S_MIX;
				end
				S_MIX: begin
					prod_q <= 48'(sd_q) * k_q;
					state_q <= S_OFF1;
				end
				S_OFF1: begin
					off_q <= 48'((64'(prod_q) * 64'(mix_q)) >>> 31);
					state_q <= S_OFF2;
				end
				S_OFF2: state_q <= S_POS;
				S_POS: begin
					state_q <= S_RUN;
				end
				// both lanes finish together: take their words
				S_RUN: if (rsp_l.done && rsp_r.done) begin
					out_ch.left  <= rsp_l.sample;
					out_ch.right <= rsp_r.sample;
					out_ch.valid <= 1'b1;
					wp_q <= wp_q + 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: if (out_ch.ready) begin
					out_ch.valid <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_OFF2)
				pos_q <= (AddrW+16)'({wp_q, 16'b0}) - (AddrW+16)'(sd_q) - (AddrW+16)'(off_q);
		end
	end

	ap_lanes_sync: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_l.done == rsp_r.done) else $error("lanes out of step");
	ap_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy |-> !in_ch.ready) else $error("accepted during clear");
	ap_wp_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> wp_q == $past(wp_q) + 1'b1) else $error("pointer slip");
endmodule
